>>> rtl/nmea_sentence_framer_top_assert.svh
// Assertion macros for the sentence framer.
`ifndef NMEA_SENTENCE_FRAMER_TOP_ASSERT_SVH
`define NMEA_SENTENCE_FRAMER_TOP_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define NSF_ASSERT_IMPLY(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("nsf assertion failed");

// Check that a condition holds in the cycle after its trigger.
`define NSF_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("nsf assertion failed");

`endif

>>> rtl/nsf_pkg.sv
package nsf_pkg;

  // Characters of the sentence grammar
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [3:0] NIB_MASK  = 4'hF;

  // Sentence kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_RMC  = 2'd1;
  localparam logic [1:0] KIND_GLL  = 2'd2;

  // Code returned for a character that is no hex digit
  localparam logic [4:0] HEX_BAD = 5'd16;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       release_primary;
    logic       release_backup;
  } in_item_t;

  typedef struct packed {
    logic       wr_en;
    logic       wr_buf;
    logic [6:0] wr_addr;
    logic [7:0] wr_data;
    logic       frame_ok;
    logic       frame_buf;
    logic [1:0] frame_type;
    logic [7:0] frame_len;
    logic       checksum_bad;
    logic       overflow;
  } out_item_t;

  // Decode one ASCII hex digit; HEX_BAD for anything else
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end else begin
      v = HEX_BAD;
    end
    return v;
  endfunction

endpackage

>>> rtl/nsf_stream_if.sv
interface nsf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/nsf_parser.sv
module nsf_parser #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  nsf_pkg::in_item_t  item,
  output nsf_pkg::out_item_t result
);
  import nsf_pkg::*;

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);

  localparam logic [3:0] ST_HUNT  = 4'd0;
  localparam logic [3:0] ST_G     = 4'd1;
  localparam logic [3:0] ST_TALK  = 4'd2;
  localparam logic [3:0] ST_SEL   = 4'd3;
  localparam logic [3:0] ST_RM    = 4'd4;
  localparam logic [3:0] ST_RMC   = 4'd5;
  localparam logic [3:0] ST_GL    = 4'd6;
  localparam logic [3:0] ST_GLL   = 4'd7;
  localparam logic [3:0] ST_COMMA = 4'd8;
  localparam logic [3:0] ST_DATA  = 4'd9;
  localparam logic [3:0] ST_HI    = 4'd10;
  localparam logic [3:0] ST_LO    = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             tgt_r, tgt_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic             pfull_r, pfull_nxt;
  logic             bfull_r, bfull_nxt;

  logic [7:0] b;
  logic       pfull_rel;
  logic       bfull_rel;
  logic [8:0] cnt_ext;

  assign b         = item.rx_byte;
  assign pfull_rel = pfull_r & ~item.release_primary;
  assign bfull_rel = bfull_r & ~item.release_backup;
  assign cnt_ext   = 9'(cnt_r);

  // Advance the sentence grammar by one byte
  always_comb begin
    state_nxt = ST_HUNT;
    xor_nxt   = xor_r;
    cnt_nxt   = cnt_r;
    tgt_nxt   = tgt_r;
    kind_nxt  = kind_r;
    pfull_nxt = pfull_rel;
    bfull_nxt = bfull_rel;
    result    = '0;
    case (state_r)
      ST_HUNT: begin
        state_nxt = (b inside {CH_DOLLAR, CH_P}) ? ST_G : ST_HUNT;
      end
      ST_G: begin
        if (b == CH_G) begin
          xor_nxt   = b;
          state_nxt = ST_TALK;
        end
      end
      ST_TALK: begin
        if (b inside {CH_P, CH_L}) begin
          xor_nxt   = xor_r ^ b;
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        if (b == CH_R) begin
          state_nxt = ST_RM;
        end else if (b == CH_G) begin
          state_nxt = ST_GL;
        end
        xor_nxt = xor_r ^ b;
      end
      ST_RM: begin
        if (b == CH_M) begin
          xor_nxt   = xor_r ^ b;
          state_nxt = ST_RMC;
        end
      end
      ST_RMC: begin
        if (b == CH_C) begin
          xor_nxt   = xor_r ^ b;
          kind_nxt  = KIND_RMC;
          state_nxt = ST_COMMA;
        end
      end
      ST_GL: begin
        if (b == CH_L) begin
          xor_nxt   = xor_r ^ b;
          state_nxt = ST_GLL;
        end
      end
      ST_GLL: begin
        if (b == CH_L) begin
          xor_nxt   = xor_r ^ b;
          kind_nxt  = KIND_GLL;
          state_nxt = ST_COMMA;
        end
      end
      ST_COMMA: begin
        if (b == CH_COMMA) begin
          // Pick a free buffer; keep the last one when both are full
          if (!pfull_rel) begin
            tgt_nxt = 1'b0;
          end else if (!bfull_rel) begin
            tgt_nxt = 1'b1;
          end
          xor_nxt   = xor_r ^ b;
          cnt_nxt   = '0;
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        if (b == CH_STAR) begin
          state_nxt = ST_HI;
        end else begin
          if (cnt_r < DEPTH_C) begin
            result.wr_en   = 1'b1;
            result.wr_buf  = tgt_r;
            result.wr_addr = cnt_ext[6:0];
            result.wr_data = b;
            cnt_nxt        = cnt_r + 1'b1;
          end else begin
            result.overflow = 1'b1;
          end
          xor_nxt   = xor_r ^ b;
          state_nxt = ST_DATA;
        end
      end
      ST_HI: begin
        if (hex_value(b) == {1'b0, xor_r[7:4]}) begin
          state_nxt = ST_LO;
        end else begin
          result.checksum_bad = 1'b1;
        end
      end
      ST_LO: begin
        if (hex_value(b) == {1'b0, xor_r[3:0] & NIB_MASK}) begin
          if (!tgt_r) begin
            pfull_nxt = 1'b1;
          end else begin
            bfull_nxt = 1'b1;
          end
          result.frame_ok   = 1'b1;
          result.frame_buf  = tgt_r;
          result.frame_type = kind_r;
          result.frame_len  = cnt_ext[7:0];
        end else begin
          result.checksum_bad = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  // Hold parser state between transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      xor_r   <= '0;
      cnt_r   <= '0;
      tgt_r   <= 1'b0;
      kind_r  <= KIND_NONE;
      pfull_r <= 1'b0;
      bfull_r <= 1'b0;
    end else if (step_en) begin
      state_r <= state_nxt;
      xor_r   <= xor_nxt;
      cnt_r   <= cnt_nxt;
      tgt_r   <= tgt_nxt;
      kind_r  <= kind_nxt;
      pfull_r <= pfull_nxt;
      bfull_r <= bfull_nxt;
    end
  end

endmodule

>>> rtl/nmea_sentence_framer_top.sv
// NMEA sentence framer.
// in_ch carries one received byte per transaction, with two release bits
// that free the primary or backup buffer before that byte is handled.
// out_ch returns exactly one result per input transaction: a buffer write
// (wr_en, wr_buf, wr_addr, wr_data), a frame-done pulse with buffer, kind
// and payload length, a checksum mismatch pulse and an overflow flag.
// A byte accepted on in_ch is held in the input register and parsed from
// there; its result is captured in the output register and offered on out_ch.
// Throughput: one byte per cycle while out_ch is not stalled; the parser
// state is a single register bank updated once per byte.
// Reset (rst_n low, synchronous) returns the parser to hunting for a start
// character, clears the checksum, count, kind and both buffer-full flags,
// and empties the input and output registers.
// When out_ch is stalled the result holds in the output register; the
// input register can still take one more byte, then in_ch.ready drops
// until the output register drains.
module nmea_sentence_framer_top #(
  parameter int BUFFER_DEPTH = 128
) (
  input logic clk,
  input logic rst_n,
  nsf_stream_if.sink   in_ch,
  nsf_stream_if.source out_ch
);
  import nsf_pkg::*;

  `include "nmea_sentence_framer_top_assert.svh"

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  logic      in_acc;
  logic      s1_adv;
  out_item_t res;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ch.ready);

  nsf_parser #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(s1_adv),
    .item   (s1_item_r),
    .result (res)
  );

  // Track valid bits of the input and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the incoming byte and the finished result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_ch.data;
    end
    if (s1_adv) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  `NSF_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, s1_adv, out_valid_r)
  `NSF_ASSERT_IMPLY(a_ok_alone, clk, rst_n, out_valid_r && out_item_r.frame_ok, !out_item_r.wr_en && !out_item_r.checksum_bad && !out_item_r.overflow)
  `NSF_ASSERT_IMPLY(a_ok_kind, clk, rst_n, out_valid_r && out_item_r.frame_ok, out_item_r.frame_type == KIND_RMC || out_item_r.frame_type == KIND_GLL)
  `NSF_ASSERT_IMPLY(a_ovf_no_wr, clk, rst_n, out_valid_r && out_item_r.overflow, !out_item_r.wr_en)

endmodule

>>> dv/nsf_frame_checker.sv
`timescale 1ns / 1ps

module nsf_frame_checker #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  nsf_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  nsf_pkg::out_item_t out_data,
  output int                 mismatch_count,
  output int                 results_pending
);
  import nsf_pkg::*;

  typedef enum logic [3:0] {
    S_HUNT, S_WAIT_G, S_TALKER, S_SELECT, S_RMC_M, S_RMC_C, S_GLL_L1, S_GLL_L2,
    S_WAIT_COMMA, S_PAYLOAD, S_CSUM_HI, S_CSUM_LO
  } parse_t;

  // Shadow copy of the parser state
  parse_t     pstate;
  logic [7:0] csum;
  logic [8:0] payload_len;
  logic       target;
  logic [1:0] kind;
  logic       primary_full;
  logic       backup_full;

  out_item_t  expected_results[$];

  // Decode one hex digit, either case; HEX_BAD for anything else
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    return HEX_BAD;
  endfunction

  // Advance the shadow parser by one byte and return the result it causes
  function automatic out_item_t frame_byte(input in_item_t it);
    out_item_t  r;
    logic [7:0] b;
    parse_t     nxt;
    r   = '0;
    b   = it.rx_byte;
    nxt = S_HUNT;
    if (it.release_primary) primary_full = 1'b0;
    if (it.release_backup) backup_full = 1'b0;
    case (pstate)
      S_HUNT: begin
        nxt = (b == CH_DOLLAR || b == CH_P) ? S_WAIT_G : S_HUNT;
      end
      S_WAIT_G: begin
        if (b == CH_G) begin
          csum = b;
          nxt  = S_TALKER;
        end
      end
      S_TALKER: begin
        if (b == CH_P || b == CH_L) begin
          csum ^= b;
          nxt   = S_SELECT;
        end
      end
      S_SELECT: begin
        if (b == CH_R) nxt = S_RMC_M;
        else if (b == CH_G) nxt = S_GLL_L1;
        csum ^= b;
      end
      S_RMC_M: begin
        if (b == CH_M) begin
          csum ^= b;
          nxt   = S_RMC_C;
        end
      end
      S_RMC_C: begin
        if (b == CH_C) begin
          csum ^= b;
          kind  = KIND_RMC;
          nxt   = S_WAIT_COMMA;
        end
      end
      S_GLL_L1: begin
        if (b == CH_L) begin
          csum ^= b;
          nxt   = S_GLL_L2;
        end
      end
      S_GLL_L2: begin
        if (b == CH_L) begin
          csum ^= b;
          kind  = KIND_GLL;
          nxt   = S_WAIT_COMMA;
        end
      end
      S_WAIT_COMMA: begin
        // pick a free buffer; with both full keep the last one
        if (b == CH_COMMA) begin
          if (!primary_full) target = 1'b0;
          else if (!backup_full) target = 1'b1;
          csum       ^= b;
          payload_len = '0;
          nxt         = S_PAYLOAD;
        end
      end
      S_PAYLOAD: begin
        if (b == CH_STAR) begin
          nxt = S_CSUM_HI;
        end else begin
          // drop bytes past the buffer depth, but keep them in the checksum
          if (payload_len < BUFFER_DEPTH) begin
            r.wr_en     = 1'b1;
            r.wr_buf    = target;
            r.wr_addr   = payload_len[6:0];
            r.wr_data   = b;
            payload_len = payload_len + 9'd1;
          end else begin
            r.overflow = 1'b1;
          end
          csum ^= b;
          nxt   = S_PAYLOAD;
        end
      end
      S_CSUM_HI: begin
        if (nibble_of(b) == {1'b0, csum[7:4]}) nxt = S_CSUM_LO;
        else r.checksum_bad = 1'b1;
      end
      S_CSUM_LO: begin
        if (nibble_of(b) == {1'b0, csum[3:0]}) begin
          if (target == 1'b0) primary_full = 1'b1;
          else backup_full = 1'b1;
          r.frame_ok   = 1'b1;
          r.frame_buf  = target;
          r.frame_type = kind;
          r.frame_len  = payload_len[7:0];
        end else begin
          r.checksum_bad = 1'b1;
        end
      end
      default: ;
    endcase
    pstate = nxt;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("ERROR %0t: %s is %0h, predicted %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Predict on each input transaction, compare on each output transaction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      pstate          = S_HUNT;
      csum            = '0;
      payload_len     = '0;
      target          = 1'b0;
      kind            = KIND_NONE;
      primary_full    = 1'b0;
      backup_full     = 1'b0;
      mismatch_count  = 0;
      results_pending = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) expected_results.push_back(frame_byte(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, wr_data", out_data.wr_data, 8'h00);
        end else begin
          want = expected_results.pop_front();
          check_field("wr_en", 8'(out_data.wr_en), 8'(want.wr_en));
          check_field("wr_buf", 8'(out_data.wr_buf), 8'(want.wr_buf));
          check_field("wr_addr", 8'(out_data.wr_addr), 8'(want.wr_addr));
          check_field("wr_data", out_data.wr_data, want.wr_data);
          check_field("frame_ok", 8'(out_data.frame_ok), 8'(want.frame_ok));
          check_field("frame_buf", 8'(out_data.frame_buf), 8'(want.frame_buf));
          check_field("frame_type", 8'(out_data.frame_type), 8'(want.frame_type));
          check_field("frame_len", out_data.frame_len, want.frame_len);
          check_field("checksum_bad", 8'(out_data.checksum_bad),
                      8'(want.checksum_bad));
          check_field("overflow", 8'(out_data.overflow), 8'(want.overflow));
        end
      end
      results_pending = expected_results.size();
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import nsf_pkg::*;

  localparam int BUFFER_DEPTH = 128;
  localparam int PHASE_BYTES  = 400;
  localparam logic [7:0] ASCII_ZERO    = "0";
  localparam logic [7:0] ASCII_UPPER_A = "A";
  localparam logic [7:0] ASCII_LOWER_A = "a";

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   phase_bytes;
  int   mismatch_count;
  int   results_pending;

  nsf_stream_if #(.T(in_item_t))  in_ch ();
  nsf_stream_if #(.T(out_item_t)) out_ch ();

  nmea_sentence_framer_top #(.BUFFER_DEPTH(BUFFER_DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  nsf_frame_checker #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_data         (in_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_data        (out_ch.data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always #5 clk = ~clk;

  // Stall the result side at random
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Give up on a hung run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return ASCII_ZERO + 8'(n);
    return (lower ? ASCII_LOWER_A : ASCII_UPPER_A) + 8'(n) - 8'd10;
  endfunction

  // Checksum from the first header letter up to the end of the queue
  function automatic logic [7:0] xor_from_g(input logic [7:0] q[$]);
    logic [7:0] s;
    s = '0;
    for (int i = 1; i < q.size(); i++) s ^= q[i];
    return s;
  endfunction

  // Present one byte, idling first at random; return at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic rel_p, input logic rel_b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {b, rel_p, rel_b};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_line(input logic [7:0] line[$], input bit releases);
    foreach (line[i]) begin
      send_byte(line[i], releases && ($urandom_range(99) < 8),
                releases && ($urandom_range(99) < 8));
    end
    phase_bytes += line.size();
  endtask

  // Build one sentence: mostly well formed, some with bad digits, cut or noise
  task automatic send_sentence();
    logic [7:0] line[$];
    logic [7:0] sum;
    logic [7:0] b;
    int         roll;
    int         len;
    int         idx;
    bit         lower;
    roll = $urandom_range(99);
    if (roll >= 90) begin
      repeat ($urandom_range(1, 8)) line.push_back(8'($urandom_range(255)));
    end else begin
      line.push_back($urandom_range(1) ? CH_DOLLAR : CH_P);
      line.push_back(CH_G);
      line.push_back($urandom_range(1) ? CH_P : CH_L);
      if ($urandom_range(1)) begin
        line.push_back(CH_R);
        line.push_back(CH_M);
        line.push_back(CH_C);
      end else begin
        line.push_back(CH_G);
        line.push_back(CH_L);
        line.push_back(CH_L);
      end
      line.push_back(CH_COMMA);
      // a few long payloads run past the buffer depth
      len = ($urandom_range(99) < 4) ? $urandom_range(BUFFER_DEPTH - 3, BUFFER_DEPTH + 6)
                                     : $urandom_range(0, 24);
      repeat (len) begin
        do b = 8'($urandom_range(255)); while (b == CH_STAR);
        line.push_back(b);
      end
      sum   = xor_from_g(line);
      lower = 1'($urandom_range(1));
      line.push_back(CH_STAR);
      line.push_back(hex_char(sum[7:4], lower));
      line.push_back(hex_char(sum[3:0], lower));
      if (roll >= 70 && roll < 80) begin
        // spoil one checksum digit, by a wrong value or a stray character
        idx = line.size() - 1 - $urandom_range(1);
        line[idx] = $urandom_range(1) ? 8'($urandom_range(255)) : (line[idx] ^ 8'h01);
      end else if (roll >= 80) begin
        // drop the tail so the parser is left mid-sentence
        line = line[0:$urandom_range(line.size() - 2)];
      end
    end
    send_line(line, 1'($urandom_range(1)));
  endtask

  initial begin
    logic [7:0] line[$];
    logic [7:0] sum;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 81;
    phase_bytes   = 0;

    // RMC with extreme payload bytes, upper-case digits
    line = '{CH_DOLLAR, CH_G, CH_P, CH_R, CH_M, CH_C, CH_COMMA, 8'h00, 8'hFF};
    sum  = xor_from_g(line);
    line.push_back(CH_STAR);
    line.push_back(hex_char(sum[7:4], 1'b0));
    line.push_back(hex_char(sum[3:0], 1'b0));
    send_line(line, 1'b0);
    // GLL with empty payload, lower-case digits, lands in the backup buffer
    line = '{CH_P, CH_G, CH_L, CH_G, CH_L, CH_L, CH_COMMA};
    sum  = xor_from_g(line);
    line.push_back(CH_STAR);
    line.push_back(hex_char(sum[7:4], 1'b1));
    line.push_back(hex_char(sum[3:0], 1'b1));
    send_line(line, 1'b0);
    // header mismatch, then free both buffers
    send_byte(CH_DOLLAR, 1'b0, 1'b0);
    send_byte(CH_G, 1'b0, 1'b0);
    send_byte(8'h58, 1'b1, 1'b1);

    // three idling phases, each drained before the next
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 28 : 0;
      while (phase_bytes < PHASE_BYTES) send_sentence();
      phase_bytes = 0;
      // hold off until every result has come back
      in_ch.valid <= 1'b0;
      wait (results_pending == 0);
      @(negedge clk);
    end

    in_ch.valid <= 1'b0;
    wait (results_pending == 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/nsf_pkg.sv
rtl/nsf_stream_if.sv
rtl/nsf_parser.sv
rtl/nmea_sentence_framer_top.sv
dv/nsf_frame_checker.sv
dv/tb_top.sv
